// File: rtl/mlpq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlpq_pkg: shared types and constants of the multilevel priority ready queue
// Holds the transfer payload types, action and status codes, the controller
// states and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package mlpq_pkg;

    // Default configuration of the queue.
    localparam int PRIO_LEVELS_DEF = 8;
    localparam int LEVEL_DEPTH_DEF = 16;
    localparam int ID_BITS_DEF     = 8;

    typedef enum logic [2:0] {
        ACT_ADD     = 3'd0,
        ACT_REMOVE  = 3'd1,
        ACT_YIELD   = 3'd2,
        ACT_PREEMPT = 3'd3,
        ACT_EXIT    = 3'd4,
        ACT_BLOCK   = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_DROP  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] thread_id;
        logic [7:0] priority_req;
    } item_t;

    typedef struct packed {
        logic [7:0] running_id;
        logic       running_valid;
        logic       switched;
        logic [1:0] status;
    } result_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_ADD,
        S_REQUEUE,
        S_PICK,
        S_PICK_RD,
        S_PICK_WAIT,
        S_RM_LEVEL,
        S_RM_SCAN,
        S_DONE
    } state_t;

    // How the datapath updates its working level register.
    typedef enum logic [2:0] {
        LVL_HOLD,
        LVL_PRIO,
        LVL_RUN,
        LVL_ZERO,
        LVL_INC,
        LVL_PICK
    } lvl_op_t;

    typedef struct packed {
        logic    load;
        lvl_op_t lvl_op;
        logic    push_new;
        logic    push_run;
        logic    clr_run;
        logic    set_drop;
        logic    pick_rd;
        logic    pick_take;
        logic    pick_none;
        logic    rm_start;
        logic    rm_step;
        logic    emit;
    } ctrl_cmd_t;

    typedef struct packed {
        action_t action;
        logic    level_full;
        logic    level_empty;
        logic    any_ready;
        logic    running;
        logic    last_level;
        logic    rm_last;
    } dp_stat_t;

endpackage

// File: rtl/mlpq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlpq_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mlpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/mlpq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlpq_ctrl: sequencing state machine of the ready queue
// Decodes the accepted action and steps the datapath through push, pick and
// remove sequences, one command bundle per cycle.
// ----------------------------------------------------------------------------
module mlpq_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  mlpq_pkg::dp_stat_t   stat,
    output mlpq_pkg::ctrl_cmd_t  cmd
);

    mlpq_pkg::state_t state_reg;
    mlpq_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mlpq_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.lvl_op = mlpq_pkg::LVL_HOLD;
        busy       = (state_reg != mlpq_pkg::S_IDLE);
        case (state_reg)
            mlpq_pkg::S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = mlpq_pkg::S_DECODE;
                end
            end
            mlpq_pkg::S_DECODE:
            begin
                case (stat.action)
                    mlpq_pkg::ACT_ADD:
                    begin
                        cmd.lvl_op = mlpq_pkg::LVL_PRIO;
                        state_next = mlpq_pkg::S_ADD;
                    end
                    mlpq_pkg::ACT_REMOVE:
                    begin
                        cmd.lvl_op = mlpq_pkg::LVL_ZERO;
                        state_next = mlpq_pkg::S_RM_LEVEL;
                    end
                    mlpq_pkg::ACT_YIELD, mlpq_pkg::ACT_PREEMPT:
                    begin
                        cmd.lvl_op = mlpq_pkg::LVL_RUN;
                        state_next = mlpq_pkg::S_REQUEUE;
                    end
                    mlpq_pkg::ACT_EXIT, mlpq_pkg::ACT_BLOCK:
                    begin
                        cmd.clr_run = 1'b1;
                        state_next  = mlpq_pkg::S_PICK;
                    end
                    default:
                    begin
                        state_next = mlpq_pkg::S_DONE;
                    end
                endcase
            end
            mlpq_pkg::S_ADD:
            begin
                if (stat.level_full)
                begin
                    cmd.set_drop = 1'b1;
                end
                else
                begin
                    cmd.push_new = 1'b1;
                end
                state_next = mlpq_pkg::S_DONE;
            end
            mlpq_pkg::S_REQUEUE:
            begin
                if (!stat.running)
                begin
                    state_next = (stat.action == mlpq_pkg::ACT_PREEMPT) ?
                                 mlpq_pkg::S_PICK : mlpq_pkg::S_DONE;
                end
                else if (stat.level_full)
                begin
                    // The running thread cannot be queued, so it keeps the CPU.
                    state_next = mlpq_pkg::S_DONE;
                end
                else
                begin
                    cmd.push_run = 1'b1;
                    state_next   = mlpq_pkg::S_PICK;
                end
            end
            mlpq_pkg::S_PICK:
            begin
                if (!stat.any_ready)
                begin
                    cmd.pick_none = 1'b1;
                    state_next    = mlpq_pkg::S_DONE;
                end
                else
                begin
                    cmd.lvl_op = mlpq_pkg::LVL_PICK;
                    state_next = mlpq_pkg::S_PICK_RD;
                end
            end
            mlpq_pkg::S_PICK_RD:
            begin
                cmd.pick_rd = 1'b1;
                state_next  = mlpq_pkg::S_PICK_WAIT;
            end
            mlpq_pkg::S_PICK_WAIT:
            begin
                cmd.pick_take = 1'b1;
                state_next    = mlpq_pkg::S_DONE;
            end
            mlpq_pkg::S_RM_LEVEL:
            begin
                if (!stat.level_empty)
                begin
                    cmd.rm_start = 1'b1;
                    state_next   = mlpq_pkg::S_RM_SCAN;
                end
                else if (stat.last_level)
                begin
                    state_next = mlpq_pkg::S_DONE;
                end
                else
                begin
                    cmd.lvl_op = mlpq_pkg::LVL_INC;
                end
            end
            mlpq_pkg::S_RM_SCAN:
            begin
                cmd.rm_step = 1'b1;
                if (stat.rm_last)
                begin
                    if (stat.last_level)
                    begin
                        state_next = mlpq_pkg::S_DONE;
                    end
                    else
                    begin
                        cmd.lvl_op = mlpq_pkg::LVL_INC;
                        state_next = mlpq_pkg::S_RM_LEVEL;
                    end
                end
            end
            mlpq_pkg::S_DONE:
            begin
                cmd.emit   = 1'b1;
                state_next = mlpq_pkg::S_IDLE;
            end
            default:
            begin
                state_next = mlpq_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/mlpq_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlpq_dpath: ready queue datapath
// Per-level head and count registers, the slot RAM, the running thread
// registers and the result register, driven by the controller's commands.
// ----------------------------------------------------------------------------
module mlpq_dpath #(
    parameter int PRIO_LEVELS = mlpq_pkg::PRIO_LEVELS_DEF,
    parameter int LEVEL_DEPTH = mlpq_pkg::LEVEL_DEPTH_DEF,
    parameter int ID_BITS     = mlpq_pkg::ID_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mlpq_pkg::item_t      item,
    input  mlpq_pkg::ctrl_cmd_t  cmd,
    output mlpq_pkg::dp_stat_t   stat,
    output logic                 done,
    output mlpq_pkg::result_t    result
);

    localparam int LVL_W = (PRIO_LEVELS > 1) ? $clog2(PRIO_LEVELS) : 1;
    localparam int POS_W = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
    localparam int CNT_W = $clog2(LEVEL_DEPTH + 1);
    localparam int SLOTS = PRIO_LEVELS * (1 << POS_W);
    localparam int ADR_W = LVL_W + POS_W;

    // Adds two in-range positions; the sum stays below twice the depth.
    function automatic logic [POS_W-1:0] wrap_add(input logic [POS_W-1:0] a,
                                                  input logic [POS_W-1:0] b);
        logic [POS_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (POS_W + 1)'(LEVEL_DEPTH))
        begin
            s = s - (POS_W + 1)'(LEVEL_DEPTH);
        end
        return s[POS_W-1:0];
    endfunction

    mlpq_pkg::item_t   item_reg,     item_next;
    logic [LVL_W-1:0]  lvl_reg,      lvl_next;
    logic [POS_W-1:0]  heads_reg  [PRIO_LEVELS];
    logic [CNT_W-1:0]  counts_reg [PRIO_LEVELS];
    logic [ID_BITS-1:0] run_id_reg,  run_id_next;
    logic [LVL_W-1:0]  run_lvl_reg,  run_lvl_next;
    logic              run_flag_reg, run_flag_next;
    logic              had_reg,      had_next;
    mlpq_pkg::status_t status_reg,   status_next;
    logic              switched_reg, switched_next;
    logic [POS_W-1:0]  rm_i_reg,     rm_i_next;
    logic [POS_W-1:0]  rm_n_reg,     rm_n_next;
    mlpq_pkg::result_t result_reg,   result_next;
    logic              done_reg,     done_next;

    logic              head_wr;
    logic [POS_W-1:0]  head_next;
    logic              cnt_wr;
    logic [CNT_W-1:0]  cnt_next;

    logic [POS_W-1:0]   cur_head;
    logic [CNT_W-1:0]   cur_cnt;
    logic [ID_BITS+7:0] id_ext;
    logic [ID_BITS-1:0] id_w;
    logic [ID_BITS+7:0] run_ext;
    logic [LVL_W-1:0]   prio_sat;
    logic [PRIO_LEVELS-1:0] nonempty;
    logic [LVL_W-1:0]   pick_lvl;
    logic               rm_keep;

    logic               ram_we;
    logic [ADR_W-1:0]   ram_waddr;
    logic [ID_BITS-1:0] ram_wdata;
    logic               ram_re;
    logic [ADR_W-1:0]   ram_raddr;
    logic [ID_BITS-1:0] ram_rdata;

    mlpq_ram #(
        .WIDTH (ID_BITS),
        .DEPTH (SLOTS)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cur_head = heads_reg[lvl_reg];
    assign cur_cnt  = counts_reg[lvl_reg];
    assign id_ext   = {{ID_BITS{1'b0}}, item_reg.thread_id};
    assign id_w     = id_ext[ID_BITS-1:0];
    assign run_ext  = {8'd0, run_id_reg};
    assign prio_sat = (item_reg.priority_req > 8'(PRIO_LEVELS - 1)) ?
                      LVL_W'(PRIO_LEVELS - 1) : item_reg.priority_req[LVL_W-1:0];
    assign rm_keep  = (ram_rdata != id_w);

    // Highest non-empty level, level 0 first.
    always_comb
    begin
        pick_lvl = '0;
        for (int l = PRIO_LEVELS - 1; l >= 0; l--)
        begin
            nonempty[l] = (counts_reg[l] != '0);
            if (nonempty[l])
            begin
                pick_lvl = LVL_W'(l);
            end
        end
    end

    always_comb
    begin
        stat.action      = mlpq_pkg::action_t'(item_reg.action);
        stat.level_full  = (cur_cnt == CNT_W'(LEVEL_DEPTH));
        stat.level_empty = (cur_cnt == '0);
        stat.any_ready   = (nonempty != '0);
        stat.running     = run_flag_reg;
        stat.last_level  = (lvl_reg == LVL_W'(PRIO_LEVELS - 1));
        stat.rm_last     = ((CNT_W'(rm_i_reg) + CNT_W'(1)) == cur_cnt);
    end

    always_comb
    begin
        item_next     = item_reg;
        lvl_next      = lvl_reg;
        run_id_next   = run_id_reg;
        run_lvl_next  = run_lvl_reg;
        run_flag_next = run_flag_reg;
        had_next      = had_reg;
        status_next   = status_reg;
        switched_next = switched_reg;
        rm_i_next     = rm_i_reg;
        rm_n_next     = rm_n_reg;
        result_next   = result_reg;
        done_next     = 1'b0;
        head_wr       = 1'b0;
        head_next     = cur_head;
        cnt_wr        = 1'b0;
        cnt_next      = cur_cnt;
        ram_we        = 1'b0;
        ram_waddr     = {lvl_reg, wrap_add(cur_head, cur_cnt[POS_W-1:0])};
        ram_wdata     = id_w;
        ram_re        = 1'b0;
        ram_raddr     = {lvl_reg, cur_head};

        case (cmd.lvl_op)
            mlpq_pkg::LVL_PRIO: lvl_next = prio_sat;
            mlpq_pkg::LVL_RUN:  lvl_next = run_lvl_reg;
            mlpq_pkg::LVL_ZERO: lvl_next = '0;
            mlpq_pkg::LVL_INC:  lvl_next = lvl_reg + LVL_W'(1);
            mlpq_pkg::LVL_PICK: lvl_next = pick_lvl;
            default:            lvl_next = lvl_reg;
        endcase

        if (cmd.load)
        begin
            item_next     = item;
            had_next      = run_flag_reg;
            status_next   = mlpq_pkg::STAT_OK;
            switched_next = 1'b0;
        end

        if (cmd.push_new)
        begin
            ram_we   = 1'b1;
            cnt_wr   = 1'b1;
            cnt_next = cur_cnt + CNT_W'(1);
        end

        if (cmd.push_run)
        begin
            ram_we        = 1'b1;
            ram_wdata     = run_id_reg;
            cnt_wr        = 1'b1;
            cnt_next      = cur_cnt + CNT_W'(1);
            run_flag_next = 1'b0;
        end

        if (cmd.clr_run)
        begin
            run_flag_next = 1'b0;
            had_next      = 1'b0;
        end

        if (cmd.set_drop)
        begin
            status_next = mlpq_pkg::STAT_DROP;
        end

        if (cmd.pick_rd)
        begin
            ram_re    = 1'b1;
            head_wr   = 1'b1;
            head_next = wrap_add(cur_head, POS_W'(1));
            cnt_wr    = 1'b1;
            cnt_next  = cur_cnt - CNT_W'(1);
        end

        if (cmd.pick_take)
        begin
            run_id_next   = ram_rdata;
            run_lvl_next  = lvl_reg;
            run_flag_next = 1'b1;
            switched_next = !(had_reg && (ram_rdata == run_id_reg));
        end

        if (cmd.pick_none)
        begin
            run_id_next   = '0;
            run_lvl_next  = '0;
            run_flag_next = 1'b0;
            status_next   = mlpq_pkg::STAT_EMPTY;
        end

        if (cmd.rm_start)
        begin
            ram_re    = 1'b1;
            rm_i_next = '0;
            rm_n_next = '0;
        end

        if (cmd.rm_step)
        begin
            // Compact in place: kept entries move down to the write index.
            ram_we    = rm_keep;
            ram_waddr = {lvl_reg, wrap_add(cur_head, rm_n_reg)};
            ram_wdata = ram_rdata;
            ram_re    = !stat.rm_last;
            ram_raddr = {lvl_reg, wrap_add(cur_head, rm_i_reg + POS_W'(1))};
            rm_i_next = rm_i_reg + POS_W'(1);
            rm_n_next = rm_n_reg + POS_W'(rm_keep);
            if (stat.rm_last)
            begin
                cnt_wr   = 1'b1;
                cnt_next = CNT_W'(rm_n_reg) + CNT_W'(rm_keep);
            end
        end

        if (cmd.emit)
        begin
            done_next                 = 1'b1;
            result_next.running_id    = run_flag_reg ? run_ext[7:0] : 8'd0;
            result_next.running_valid = run_flag_reg;
            result_next.switched      = switched_reg;
            result_next.status        = status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lvl_reg      <= '0;
            run_id_reg   <= '0;
            run_lvl_reg  <= '0;
            run_flag_reg <= 1'b0;
            had_reg      <= 1'b0;
            status_reg   <= mlpq_pkg::STAT_OK;
            switched_reg <= 1'b0;
            rm_i_reg     <= '0;
            rm_n_reg     <= '0;
            done_reg     <= 1'b0;
            for (int l = 0; l < PRIO_LEVELS; l++)
            begin
                heads_reg[l]  <= '0;
                counts_reg[l] <= '0;
            end
        end
        else
        begin
            lvl_reg      <= lvl_next;
            run_id_reg   <= run_id_next;
            run_lvl_reg  <= run_lvl_next;
            run_flag_reg <= run_flag_next;
            had_reg      <= had_next;
            status_reg   <= status_next;
            switched_reg <= switched_next;
            rm_i_reg     <= rm_i_next;
            rm_n_reg     <= rm_n_next;
            done_reg     <= done_next;
            if (head_wr)
            begin
                heads_reg[lvl_reg] <= head_next;
            end
            if (cnt_wr)
            begin
                counts_reg[lvl_reg] <= cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// File: rtl/multilevel_priority_ready_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multilevel_priority_ready_queue: priority round-robin thread scheduler
// Keeps one FIFO of thread ids per priority level and the running thread,
// and performs add, remove, yield, preempt, exit and block actions.
// ----------------------------------------------------------------------------
// Drive start with an action in item while busy is low; that transfer is
// taken at the clock edge and exactly one result follows, shown on result
// for a single cycle while done is high. The receiver cannot stall it, so
// done must be sampled every cycle. A remove visits every level and every
// queued entry. A pick that finds nothing runnable skips the S_PICK_RD and
// S_PICK_WAIT states that one dispatching a thread passes through. The
// remove time is set by the slot RAM: it has one read and one write port,
// and each level is compacted in place one entry per cycle. A pick also
// waits in S_PICK_WAIT for the registered RAM read.
// The done strobe rises in the cycle in which busy has fallen, so the next
// start may be given in the same cycle that the result appears.
// ----------------------------------------------------------------------------
module multilevel_priority_ready_queue #(
    parameter int PRIO_LEVELS = mlpq_pkg::PRIO_LEVELS_DEF,
    parameter int LEVEL_DEPTH = mlpq_pkg::LEVEL_DEPTH_DEF,
    parameter int ID_BITS     = mlpq_pkg::ID_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  mlpq_pkg::item_t   item,
    output logic              done,
    output mlpq_pkg::result_t result
);

    // The controller only sequences; every piece of queue state sits in
    // the datapath, and the two talk through one command and one status
    // bundle.
    mlpq_pkg::ctrl_cmd_t cmd;
    mlpq_pkg::dp_stat_t  stat;

    mlpq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    // The datapath latches the item on the accepting transfer and drives
    // the result register that done qualifies.
    mlpq_dpath #(
        .PRIO_LEVELS (PRIO_LEVELS),
        .LEVEL_DEPTH (LEVEL_DEPTH),
        .ID_BITS     (ID_BITS)
    ) u_dpath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .stat   (stat),
        .done   (done),
        .result (result)
    );

endmodule

// File: rtl/mlpq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlpq_checker: port-level checks of the ready queue
// Watches the handshake and the consistency of the result fields.
// ----------------------------------------------------------------------------
module mlpq_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input mlpq_pkg::result_t result
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not rise after an accepted transfer");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without preceding work");

    a_idle_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.running_valid) |-> (result.running_id == 8'd0))
        else $error("nonzero running_id with nothing running");

    a_switch_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.switched) |->
        (result.running_valid && (result.status == mlpq_pkg::STAT_OK)))
        else $error("switch reported without a running thread");

    a_empty_pick: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status == mlpq_pkg::STAT_EMPTY)) |->
        (!result.running_valid && !result.switched))
        else $error("empty pick reported with a running thread");

endmodule

bind multilevel_priority_ready_queue mlpq_checker u_mlpq_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
